[rtl/fixed_point_to_radix_string_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the fixed-point to radix text converter
// Concurrent assertion wrappers, clocked on the rising edge.
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_TO_RADIX_STRING_MACROS_SVH
`define FIXED_POINT_TO_RADIX_STRING_MACROS_SVH

// checked outside reset only
`define FPR_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked at every edge, reset included
`define FPR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/fpr_pkg.sv]
// ----------------------------------------------------------------------------
// fpr_pkg
// Types, constants and helpers shared by the radix text converter.
// ----------------------------------------------------------------------------
package fpr_pkg;

    localparam int DEF_INT_BITS        = 32;
    localparam int DEF_FRAC_BITS       = 16;
    localparam int DEF_MAX_FRAC_DIGITS = 16;

    localparam int CFG_W          = 5;
    localparam int DIV_STEP_BITS  = 8;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [CFG_W-1:0] BASE_MIN   = 5'd2;
    localparam logic [CFG_W-1:0] BASE_MAX   = 5'd16;
    localparam logic [CFG_W-1:0] BASE_RESET = 5'd10;
    localparam logic [CFG_W-1:0] PREC_RESET = 5'd4;

    localparam logic [0:0] REG_BASE      = 1'b0;
    localparam logic [0:0] REG_PRECISION = 1'b1;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [3:0] DIGIT_TEN  = 4'd10;

    typedef struct packed {
        logic full;
        logic empty;
    } fpr_q_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_FRAC,
        ST_SIGN,
        ST_INT,
        ST_DOT,
        ST_FDIG
    } fpr_state_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        if (d < DIGIT_TEN)
            return CHAR_ZERO + {4'b0000, d};
        else
            return CHAR_A + {4'b0000, d - DIGIT_TEN};
    endfunction

endpackage

[rtl/fpr_queue.sv]
// ----------------------------------------------------------------------------
// fpr_queue
// Small register queue between the front and back parts.
// ----------------------------------------------------------------------------
module fpr_queue
    import fpr_pkg::*;
#(
    parameter int WIDTH = 49,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output fpr_q_status_t    status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wptr_reg, wptr_next;
    logic [PW-1:0]    rptr_reg, rptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign status.full  = (count_reg == CW'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_data     = slot_reg[rptr_reg];

    always_comb begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_push) begin
            wptr_next = (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop) begin
            rptr_next = (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wptr_reg] <= push_data;
        end
    end

endmodule

[rtl/fpr_front.sv]
// ----------------------------------------------------------------------------
// fpr_front
// Accepts input requests, splits sign and magnitude, feeds the queue.
// ----------------------------------------------------------------------------
module fpr_front
    import fpr_pkg::*;
#(
    parameter int VW = DEF_INT_BITS + DEF_FRAC_BITS
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [VW-1:0] value,
    input  fpr_q_status_t q_status,
    output logic          q_push,
    output logic [VW:0]   q_data
);

    logic          hold_valid_reg, hold_valid_next;
    logic [VW:0]   hold_data_reg;
    logic          neg;
    logic [VW-1:0] mag;
    logic          accept;

    assign s_tready = !hold_valid_reg || !q_status.full;
    assign accept   = s_tvalid && s_tready;
    assign q_push   = hold_valid_reg && !q_status.full;
    assign q_data   = hold_data_reg;

    // two's complement magnitude; the most negative value maps onto itself
    assign neg = value[VW-1];
    assign mag = neg ? VW'(~value + VW'(1)) : value;

    always_comb begin
        hold_valid_next = hold_valid_reg;
        if (accept)
            hold_valid_next = 1'b1;
        else if (q_push)
            hold_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            hold_data_reg <= {neg, mag};
        end
    end

endmodule

[rtl/fpr_back.sv]
// ----------------------------------------------------------------------------
// fpr_back
// Digit generation (integer by chunked division, fraction by multiply)
// and character emission through an output register.
// ----------------------------------------------------------------------------
module fpr_back
    import fpr_pkg::*;
#(
    parameter int INT_BITS        = DEF_INT_BITS,
    parameter int FRAC_BITS       = DEF_FRAC_BITS,
    parameter int MAX_FRAC_DIGITS = DEF_MAX_FRAC_DIGITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [CFG_W-1:0]              base_cfg,
    input  logic [CFG_W-1:0]              precision_cfg,
    input  fpr_q_status_t                 q_status,
    input  logic [INT_BITS+FRAC_BITS:0]   q_data,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,
    output logic                          m_tlast
);

    localparam int VW     = INT_BITS + FRAC_BITS;
    localparam int NCHUNK = (INT_BITS + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
    localparam int DVW    = NCHUNK * DIV_STEP_BITS;
    localparam int CHW    = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int IIW    = $clog2(INT_BITS);
    localparam int ICW    = $clog2(INT_BITS + 1);
    localparam int FIW    = (MAX_FRAC_DIGITS > 1) ? $clog2(MAX_FRAC_DIGITS) : 1;
    localparam int FCW    = $clog2(MAX_FRAC_DIGITS + 1);
    localparam int PW     = FRAC_BITS + CFG_W;

    fpr_state_t state_reg, state_next;

    logic                 neg_reg, neg_next;
    logic [DVW-1:0]       dvd_reg, dvd_next;
    logic [3:0]           rem_reg, rem_next;
    logic [CHW-1:0]       chunk_reg, chunk_next;
    logic [ICW-1:0]       icnt_reg, icnt_next;
    logic [CFG_W-1:0]     p_reg, p_next;
    logic [FCW-1:0]       prec_reg, prec_next;
    logic [FRAC_BITS-1:0] fr_reg, fr_next;
    logic [FCW-1:0]       fcnt_reg, fcnt_next;
    logic [FCW-1:0]       kept_reg, kept_next;
    logic [IIW-1:0]       iidx_reg, iidx_next;
    logic [FCW-1:0]       fidx_reg, fidx_next;
    logic                 ovalid_reg, ovalid_next;
    logic [7:0]           ochar_reg, ochar_next;
    logic                 olast_reg, olast_next;

    logic [3:0]           int_dig_mem  [INT_BITS];
    logic [3:0]           frac_dig_mem [MAX_FRAC_DIGITS];
    logic [3:0]           irdata_reg, frdata_reg;
    logic                 int_we, frac_we;

    logic [4:0]               div_r;
    logic [DIV_STEP_BITS-1:0] div_q;
    logic [DVW-1:0]           dvd_step;
    logic [PW-1:0]            prod;
    logic [3:0]               frac_digit;
    logic                     out_free;
    logic [VW-1:0]            in_mag;
    logic [CFG_W-1:0]         p_clamped;
    logic [FCW-1:0]           prec_clamped;

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = ochar_reg;
    assign m_tlast  = olast_reg;
    assign out_free = !ovalid_reg || m_tready;
    assign in_mag   = q_data[VW-1:0];

    assign p_clamped = (base_cfg < BASE_MIN) ? BASE_MIN :
                       (base_cfg > BASE_MAX) ? BASE_MAX : base_cfg;
    assign prec_clamped = (int'(precision_cfg) > MAX_FRAC_DIGITS) ?
                          FCW'(MAX_FRAC_DIGITS) : FCW'(precision_cfg);

    // one chunk of restoring division by the radix
    always_comb begin
        div_r = {1'b0, rem_reg};
        div_q = '0;
        for (int k = 0; k < DIV_STEP_BITS; k++) begin
            div_r = {div_r[3:0], dvd_reg[DVW-1-k]};
            if (div_r >= p_reg) begin
                div_r = div_r - p_reg;
                div_q[DIV_STEP_BITS-1-k] = 1'b1;
            end
        end
        dvd_step = (dvd_reg << DIV_STEP_BITS) | DVW'(div_q);
    end

    assign prod       = PW'(fr_reg) * PW'(p_reg);
    assign frac_digit = prod[FRAC_BITS+3:FRAC_BITS];

    always_comb begin
        state_next  = state_reg;
        neg_next    = neg_reg;
        dvd_next    = dvd_reg;
        rem_next    = rem_reg;
        chunk_next  = chunk_reg;
        icnt_next   = icnt_reg;
        p_next      = p_reg;
        prec_next   = prec_reg;
        fr_next     = fr_reg;
        fcnt_next   = fcnt_reg;
        kept_next   = kept_reg;
        iidx_next   = (state_reg == ST_INT) ? iidx_reg : IIW'(icnt_reg - 1'b1);
        fidx_next   = (state_reg == ST_FDIG) ? fidx_reg : '0;
        ovalid_next = ovalid_reg && !m_tready;
        ochar_next  = ochar_reg;
        olast_next  = olast_reg;
        q_pop       = 1'b0;
        int_we      = 1'b0;
        frac_we     = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (!q_status.empty) begin
                    q_pop      = 1'b1;
                    neg_next   = q_data[VW];
                    dvd_next   = DVW'(in_mag[VW-1:FRAC_BITS]);
                    fr_next    = in_mag[FRAC_BITS-1:0];
                    rem_next   = '0;
                    chunk_next = '0;
                    icnt_next  = '0;
                    fcnt_next  = '0;
                    kept_next  = '0;
                    p_next     = p_clamped;
                    prec_next  = prec_clamped;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                dvd_next = dvd_step;
                rem_next = div_r[3:0];
                if (chunk_reg == CHW'(NCHUNK - 1)) begin
                    int_we     = 1'b1;
                    icnt_next  = icnt_reg + 1'b1;
                    rem_next   = '0;
                    chunk_next = '0;
                    if (dvd_step == '0)
                        state_next = ST_FRAC;
                end else begin
                    chunk_next = chunk_reg + 1'b1;
                end
            end
            ST_FRAC: begin
                if (fcnt_reg == prec_reg) begin
                    state_next = neg_reg ? ST_SIGN : ST_INT;
                end else begin
                    frac_we   = 1'b1;
                    fr_next   = prod[FRAC_BITS-1:0];
                    fcnt_next = fcnt_reg + 1'b1;
                    if (frac_digit != 4'd0)
                        kept_next = fcnt_reg + 1'b1;
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    ovalid_next = 1'b1;
                    ochar_next  = CHAR_MINUS;
                    olast_next  = 1'b0;
                    state_next  = ST_INT;
                end
            end
            ST_INT: begin
                if (out_free) begin
                    ovalid_next = 1'b1;
                    ochar_next  = digit_char(irdata_reg);
                    olast_next  = (iidx_reg == '0) && (kept_reg == '0);
                    if (iidx_reg == '0)
                        state_next = (kept_reg != '0) ? ST_DOT : ST_IDLE;
                    else
                        iidx_next = iidx_reg - 1'b1;
                end
            end
            ST_DOT: begin
                if (out_free) begin
                    ovalid_next = 1'b1;
                    ochar_next  = CHAR_DOT;
                    olast_next  = 1'b0;
                    state_next  = ST_FDIG;
                end
            end
            ST_FDIG: begin
                if (out_free) begin
                    ovalid_next = 1'b1;
                    ochar_next  = digit_char(frdata_reg);
                    olast_next  = (fidx_reg == kept_reg - 1'b1);
                    if (fidx_reg == kept_reg - 1'b1)
                        state_next = ST_IDLE;
                    else
                        fidx_next = fidx_reg + 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        neg_reg   <= neg_next;
        dvd_reg   <= dvd_next;
        rem_reg   <= rem_next;
        chunk_reg <= chunk_next;
        icnt_reg  <= icnt_next;
        p_reg     <= p_next;
        prec_reg  <= prec_next;
        fr_reg    <= fr_next;
        fcnt_reg  <= fcnt_next;
        kept_reg  <= kept_next;
        iidx_reg  <= iidx_next;
        fidx_reg  <= fidx_next;
        ochar_reg <= ochar_next;
        olast_reg <= olast_next;
    end

    // digit stores with registered reads, addressed by the next index so the digit is ready at emission
    always_ff @(posedge aclk) begin
        if (int_we) begin
            int_dig_mem[icnt_reg[IIW-1:0]] <= div_r[3:0];
        end
        irdata_reg <= int_dig_mem[iidx_next];
    end

    always_ff @(posedge aclk) begin
        if (frac_we) begin
            frac_dig_mem[fcnt_reg[FIW-1:0]] <= frac_digit;
        end
        frdata_reg <= frac_dig_mem[fidx_next[FIW-1:0]];
    end

endmodule

[rtl/fixed_point_to_radix_string.sv]
// ----------------------------------------------------------------------------
// fixed_point_to_radix_string
// Signed fixed-point number to ASCII text in a configurable radix.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one number per request: two's complement, FRAC_BITS
//   fraction bits. m_axis returns its text one character per request,
//   tlast on the final one: optional '-', integer digits (MSD first),
//   then '.' and fraction digits with trailing zeros trimmed.
//   cfg_we/cfg_addr/cfg_wdata write base (index 0) and precision (index 1);
//   write them only while the block is idle.
// Flow:
//   Per number: a load, then integer digits by chunked division (8
//   quotient bits a cycle), fraction digits by repeated multiply by the
//   base, then the characters one at a time.
//   Numbers run one at a time in the digit engine; a two-entry queue and
//   an input register let up to three more be taken meanwhile.
// Reset: aresetn clears the queue, the engine and the output valid;
//   base returns to 10 and precision to 4.
// Stall: a held m_axis_tready freezes the output register and emission;
//   digits are still made; input is taken until queue and input register fill.
// ----------------------------------------------------------------------------
module fixed_point_to_radix_string
    import fpr_pkg::*;
#(
    parameter int INT_BITS        = DEF_INT_BITS,
    parameter int FRAC_BITS       = DEF_FRAC_BITS,
    parameter int MAX_FRAC_DIGITS = DEF_MAX_FRAC_DIGITS
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [0:0]       cfg_addr,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // [INT_BITS+FRAC_BITS-1:0] value, rest zero
    input  logic [((INT_BITS+FRAC_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // [7:0] character
    output logic [7:0]       m_axis_tdata,
    output logic             m_axis_tlast
);

    localparam int VW = INT_BITS + FRAC_BITS;

    logic [CFG_W-1:0] base_reg, base_next;
    logic [CFG_W-1:0] precision_reg, precision_next;
    fpr_q_status_t    q_status;
    logic             q_push, q_pop;
    logic [VW:0]      q_in, q_out;

    always_comb begin
        base_next      = base_reg;
        precision_next = precision_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                REG_BASE:      base_next      = cfg_wdata;
                REG_PRECISION: precision_next = cfg_wdata;
                default:       base_next      = base_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg      <= BASE_RESET;
            precision_reg <= PREC_RESET;
        end else begin
            base_reg      <= base_next;
            precision_reg <= precision_next;
        end
    end

    fpr_front #(
        .VW(VW)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .value    (s_axis_tdata[VW-1:0]),
        .q_status (q_status),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    fpr_queue #(
        .WIDTH(VW + 1),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .status    (q_status)
    );

    fpr_back #(
        .INT_BITS        (INT_BITS),
        .FRAC_BITS       (FRAC_BITS),
        .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .base_cfg      (base_reg),
        .precision_cfg (precision_reg),
        .q_status      (q_status),
        .q_data        (q_out),
        .q_pop         (q_pop),
        .m_tvalid      (m_axis_tvalid),
        .m_tready      (m_axis_tready),
        .m_tdata       (m_axis_tdata),
        .m_tlast       (m_axis_tlast)
    );

endmodule

[rtl/fpr_checker.sv]
// ----------------------------------------------------------------------------
// fpr_checker
// Port-level checks on the character stream of the converter.
// ----------------------------------------------------------------------------
`include "fixed_point_to_radix_string_macros.svh"

module fpr_checker
    import fpr_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast
);

    `FPR_ASSERT(a_out_hold, aclk, aresetn, (m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)), "stalled output changed")
    `FPR_ASSERT_ALWAYS(a_reset_clears, aclk, (!aresetn |=> !m_axis_tvalid), "output valid after reset")
    `FPR_ASSERT(a_sign_dot_not_last, aclk, aresetn, (m_axis_tvalid && (m_axis_tdata == CHAR_MINUS || m_axis_tdata == CHAR_DOT) |-> !m_axis_tlast), "text ends in sign or dot")
    `FPR_ASSERT(a_char_set, aclk, aresetn, (m_axis_tvalid |-> (m_axis_tdata == CHAR_MINUS || m_axis_tdata == CHAR_DOT || (m_axis_tdata >= CHAR_ZERO && m_axis_tdata <= CHAR_ZERO + 8'd9) || (m_axis_tdata >= CHAR_A && m_axis_tdata <= CHAR_A + 8'd5))), "character outside digit set")

endmodule

bind fixed_point_to_radix_string fpr_checker u_fpr_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
